// File: rtl/core/tfpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tfpp_pkg;

  // build-time defaults
  localparam int StreamMaxBytes = 1024;
  localparam int QueueDepth     = 4;
  localparam int ApbAddrW       = 5;
  localparam int ApbDataW       = 32;

  // register reset values
  localparam logic [7:0] HeadReset   = 8'hA5;
  localparam logic [7:0] TailReset0  = 8'h5A;
  localparam logic [7:0] TailReset1  = 8'hA5;
  localparam logic [7:0] TailReset2  = 8'h5A;
  localparam logic [7:0] TailReset3  = 8'hA5;
  localparam logic [7:0] StreamReset = 8'hFF;
  localparam logic [7:0] MaskReset   = 8'h02;
  localparam logic [7:0] LimitReset  = 8'd64;

  typedef enum logic [2:0] {
    REG_HEAD   = 3'd0,
    REG_TAIL0  = 3'd1,
    REG_TAIL1  = 3'd2,
    REG_TAIL2  = 3'd3,
    REG_TAIL3  = 3'd4,
    REG_STREAM = 3'd5,
    REG_MASK   = 3'd6,
    REG_LIMIT  = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    KIND_STD_BYTE    = 3'd0,
    KIND_STREAM_BYTE = 3'd1,
    KIND_STD_DONE    = 3'd2,
    KIND_STREAM_DONE = 3'd3,
    KIND_ABORT       = 3'd4
  } kind_e;

  typedef struct packed {
    logic [7:0] head_value;
    logic [7:0] tail_first;
    logic [7:0] tail_second;
    logic [7:0] tail_third;
    logic [7:0] tail_fourth;
    logic [7:0] streaming_length_code;
    logic [7:0] end_flag_mask;
    logic [7:0] standard_payload_limit;
  } cfg_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [9:0]  byte_index;
    logic [7:0]  source_id;
    logic [7:0]  dest_id;
    logic [7:0]  length_byte;
    logic [7:0]  command_byte;
    logic [7:0]  chunk_flags;
    logic        final_flag;
    logic [10:0] byte_total;
    logic        last;
  } out_item_t;

  // one queue entry: a bundle of 1..4 results from one input byte
  typedef struct packed {
    logic [2:0]      num;
    kind_e           kind;
    logic [3:0][7:0] bytes;
    logic [9:0]      base_index;
    logic [7:0]      source_id;
    logic [7:0]      dest_id;
    logic [7:0]      length_byte;
    logic [7:0]      command_byte;
    logic [7:0]      chunk_flags;
    logic            final_flag;
    logic [10:0]     byte_total;
  } q_entry_t;

  // queue state as seen by the front and back
  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

`default_nettype wire

// File: rtl/core/tail_framed_packet_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+------------------------------
// in        | input     | in_valid_i/in_stall_o | in_data_i  (opcode, rx_byte)
// out       | output    | out_valid_o/out_stall_i | out_data_o (one result)
// apb cfg   | input     | psel/penable/pready   | paddr, pwdata, prdata
//
// one byte is taken every cycle while the result queue has room; the front
// parser settles each byte in that cycle and queues at most one bundle of up to
// four results, which pass the queue and then the output register. the back
// end sends one result per unstalled cycle, so a byte with several results
// holds it until all are sent; the queue of QUEUE_DEPTH bundles soaks that up.
// reset empties the queue and puts the parser back to hunting the head byte

module tail_framed_packet_parser import tfpp_pkg::*; #(
  parameter int STREAM_MAX_BYTES = StreamMaxBytes,
  parameter int QUEUE_DEPTH      = QueueDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // byte input
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_item_t            in_data_i,
  // results
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_item_t                out_data_o,
  // register port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0]      prdata,
  output logic                     pready
);

  cfg_t      cfg_q;
  reg_idx_e  reg_idx;
  logic      wr_en;
  logic [7:0] rd_val;

  q_status_t q_status;
  q_entry_t  push_entry;
  q_entry_t  head_entry;
  logic      push;
  logic      pop;

  // register file: always ready, one write per access phase
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[ApbAddrW-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head_value             <= HeadReset;
      cfg_q.tail_first             <= TailReset0;
      cfg_q.tail_second            <= TailReset1;
      cfg_q.tail_third             <= TailReset2;
      cfg_q.tail_fourth            <= TailReset3;
      cfg_q.streaming_length_code  <= StreamReset;
      cfg_q.end_flag_mask          <= MaskReset;
      cfg_q.standard_payload_limit <= LimitReset;
    end else if (wr_en) begin
      case (reg_idx)
        REG_HEAD:   cfg_q.head_value             <= pwdata[7:0];
        REG_TAIL0:  cfg_q.tail_first             <= pwdata[7:0];
        REG_TAIL1:  cfg_q.tail_second            <= pwdata[7:0];
        REG_TAIL2:  cfg_q.tail_third             <= pwdata[7:0];
        REG_TAIL3:  cfg_q.tail_fourth            <= pwdata[7:0];
        REG_STREAM: cfg_q.streaming_length_code  <= pwdata[7:0];
        REG_MASK:   cfg_q.end_flag_mask          <= pwdata[7:0];
        REG_LIMIT:  cfg_q.standard_payload_limit <= pwdata[7:0];
        default:    cfg_q.head_value             <= cfg_q.head_value;
      endcase
    end
  end

  // readback
  always_comb begin
    case (reg_idx)
      REG_HEAD:   rd_val = cfg_q.head_value;
      REG_TAIL0:  rd_val = cfg_q.tail_first;
      REG_TAIL1:  rd_val = cfg_q.tail_second;
      REG_TAIL2:  rd_val = cfg_q.tail_third;
      REG_TAIL3:  rd_val = cfg_q.tail_fourth;
      REG_STREAM: rd_val = cfg_q.streaming_length_code;
      REG_MASK:   rd_val = cfg_q.end_flag_mask;
      REG_LIMIT:  rd_val = cfg_q.standard_payload_limit;
      default:    rd_val = 8'd0;
    endcase
  end
  assign prdata = {{(ApbDataW - 8){1'b0}}, rd_val};

  // front: parse state and per-byte result bundle
  tfpp_front #(
    .STREAM_MAX_BYTES (STREAM_MAX_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .q_status_i (q_status),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // bundle queue between the parser and the result sender
  tfpp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .head_o   (head_entry),
    .status_o (q_status)
  );

  // back: unpacks bundles into single result transfers
  tfpp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_entry),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // a bundle only leaves the queue when there is one
  a_pop_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_status.valid)
    else $error("pop from empty bundle queue");

  // completions and aborts are always the only result of their byte
  a_single_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind != KIND_STD_BYTE &&
     out_data_o.kind != KIND_STREAM_BYTE) |-> out_data_o.last)
    else $error("completion or abort result not marked last");

  // released stream bytes of one bundle follow back to back with rising index
  a_bundle_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.last &&
     out_data_o.kind == KIND_STREAM_BYTE) |=>
    (out_valid_o && out_data_o.byte_index == $past(out_data_o.byte_index) + 10'd1))
    else $error("stream byte bundle broke sequence");

endmodule

`default_nettype wire

// File: rtl/core/tfpp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tfpp_front import tfpp_pkg::*; #(
  parameter int STREAM_MAX_BYTES = StreamMaxBytes
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire logic     in_valid_i,
  input  wire in_item_t in_data_i,
  output logic          in_stall_o,
  input  wire q_status_t q_status_i,
  output logic          push_o,
  output q_entry_t      entry_o
);

  localparam int MaxW  = $clog2(STREAM_MAX_BYTES + 1);
  localparam int CntW  = (MaxW > 8) ? MaxW : 8;
  localparam int WideW = (CntW > 11) ? CntW : 11;
  localparam logic [CntW-1:0] CntMax = CntW'(STREAM_MAX_BYTES);

  typedef enum logic [2:0] {
    PH_HEAD, PH_SRC, PH_DST, PH_LEN, PH_CMD, PH_DATA, PH_TAIL, PH_STREAM
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [7:0]      src_q, src_d, dst_q, dst_d, len_q, len_d, cmd_q, cmd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      first_q, first_d;
  logic [1:0]      pend_q, pend_d;

  logic            accept;
  logic [7:0]      b;
  logic [7:0]      dl;
  logic [3:0][7:0] tail;
  logic [3:0][7:0] seq;
  logic            ok;
  logic [1:0]      kk;
  logic [2:0]      rel;
  logic [2:0]      nrel;
  logic [CntW-1:0] room;
  logic [WideW-1:0] cnt_wide;
  logic            go_idle;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;
  assign b          = in_data_i.rx_byte;
  assign dl         = (len_q == 8'd0) ? 8'd0 : len_q - 8'd1;
  assign tail       = {cfg_i.tail_fourth, cfg_i.tail_third, cfg_i.tail_second, cfg_i.tail_first};
  assign cnt_wide   = WideW'(cnt_q);

  // stream tail search: longest held suffix that still opens the tail
  always_comb begin
    kk = 2'd0;
    for (int k = 1; k <= 3; k++) begin
      ok = (k <= int'(pend_q)) && (b == tail[2'(k - 1)]);
      for (int j = 0; j < 2; j++) begin
        if (j < k - 1 && tail[2'(int'(pend_q) + 1 - k + j)] != tail[2'(j)]) ok = 1'b0;
      end
      if (ok) kk = 2'(k);
    end
    rel = 3'(pend_q) + 3'd1 - 3'(kk);
    for (int i = 0; i < 4; i++) begin
      seq[i] = (i < int'(pend_q)) ? tail[i] : b;
    end
    room = CntMax - cnt_q;
    nrel = (room >= CntW'(rel)) ? rel : room[2:0];
  end

  always_comb begin
    phase_d = phase_q;
    src_d   = src_q;
    dst_d   = dst_q;
    len_d   = len_q;
    cmd_d   = cmd_q;
    cnt_d   = cnt_q;
    first_d = first_q;
    pend_d  = pend_q;
    go_idle = 1'b0;
    push_o  = 1'b0;
    entry_o = '0;
    entry_o.num          = 3'd1;
    entry_o.kind         = KIND_STD_BYTE;
    entry_o.source_id    = src_q;
    entry_o.dest_id      = dst_q;
    entry_o.length_byte  = len_q;
    entry_o.command_byte = cmd_q;
    if (accept) begin
      if (in_data_i.opcode) begin
        if (phase_q != PH_HEAD) begin
          push_o             = 1'b1;
          entry_o.kind       = KIND_ABORT;
          entry_o.byte_total = cnt_wide[10:0];
        end
        go_idle = 1'b1;
      end else begin
        case (phase_q)
          PH_HEAD: begin
            if (b == cfg_i.head_value) phase_d = PH_SRC;
          end
          PH_SRC: begin
            src_d   = b;
            phase_d = PH_DST;
          end
          PH_DST: begin
            dst_d   = b;
            phase_d = PH_LEN;
          end
          PH_LEN: begin
            len_d   = b;
            phase_d = PH_CMD;
          end
          PH_CMD: begin
            cmd_d  = b;
            cnt_d  = '0;
            pend_d = 2'd0;
            if (len_q == cfg_i.streaming_length_code) begin
              phase_d = PH_STREAM;
            end else if (dl == 8'd0) begin
              phase_d = PH_TAIL;
            end else if (dl <= cfg_i.standard_payload_limit) begin
              phase_d = PH_DATA;
            end else begin
              // length over the limit
              push_o               = 1'b1;
              entry_o.kind         = KIND_ABORT;
              entry_o.command_byte = b;
              go_idle              = 1'b1;
            end
          end
          PH_DATA: begin
            push_o             = 1'b1;
            entry_o.kind       = KIND_STD_BYTE;
            entry_o.bytes[0]   = b;
            entry_o.base_index = cnt_wide[9:0];
            cnt_d              = cnt_q + CntW'(1);
            if (cnt_d >= CntW'(dl)) begin
              phase_d = PH_TAIL;
              pend_d  = 2'd0;
            end
          end
          PH_TAIL: begin
            if (b == tail[pend_q]) begin
              if (pend_q == 2'd3) begin
                push_o             = 1'b1;
                entry_o.kind       = KIND_STD_DONE;
                entry_o.byte_total = cnt_wide[10:0];
                go_idle            = 1'b1;
              end else begin
                pend_d = pend_q + 2'd1;
              end
            end else begin
              push_o             = 1'b1;
              entry_o.kind       = KIND_ABORT;
              entry_o.byte_total = cnt_wide[10:0];
              go_idle            = 1'b1;
            end
          end
          PH_STREAM: begin
            if (b == tail[pend_q]) begin
              if (pend_q == 2'd3) begin
                if (cnt_q != '0) begin
                  push_o              = 1'b1;
                  entry_o.kind        = KIND_STREAM_DONE;
                  entry_o.chunk_flags = first_q;
                  entry_o.final_flag  = |(first_q & cfg_i.end_flag_mask);
                  entry_o.byte_total  = cnt_wide[10:0];
                end
                go_idle = 1'b1;
              end else begin
                pend_d = pend_q + 2'd1;
              end
            end else begin
              // release broken-off tail bytes as payload, count saturates
              if (nrel != 3'd0) begin
                push_o             = 1'b1;
                entry_o.num        = nrel;
                entry_o.kind       = KIND_STREAM_BYTE;
                entry_o.bytes      = seq;
                entry_o.base_index = cnt_wide[9:0];
                if (cnt_q == '0) first_d = seq[0];
              end
              cnt_d  = cnt_q + CntW'(nrel);
              pend_d = kk;
            end
          end
          default: begin
            go_idle = 1'b1;
          end
        endcase
      end
    end
    if (go_idle) begin
      phase_d = PH_HEAD;
      src_d   = 8'd0;
      dst_d   = 8'd0;
      len_d   = 8'd0;
      cmd_d   = 8'd0;
      cnt_d   = '0;
      first_d = 8'd0;
      pend_d  = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD;
      src_q   <= 8'd0;
      dst_q   <= 8'd0;
      len_q   <= 8'd0;
      cmd_q   <= 8'd0;
      cnt_q   <= '0;
      first_q <= 8'd0;
      pend_q  <= 2'd0;
    end else begin
      phase_q <= phase_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      len_q   <= len_d;
      cmd_q   <= cmd_d;
      cnt_q   <= cnt_d;
      first_q <= first_d;
      pend_q  <= pend_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tfpp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tfpp_queue import tfpp_pkg::*; #(
  parameter int DEPTH = QueueDepth
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire q_entry_t entry_i,
  input  wire logic     pop_i,
  output q_entry_t      head_o,
  output q_status_t     status_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  q_entry_t        mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign status_o.full  = (cnt_q == CntW'(DEPTH));
  assign status_o.valid = (cnt_q != '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && status_o.valid;
  assign head_o         = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      if (do_pop)  rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tfpp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tfpp_back import tfpp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire q_entry_t  head_i,
  input  wire q_status_t q_status_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o
);

  logic       load;
  logic       at_end;
  logic [1:0] sub_q;
  out_item_t  res;
  out_item_t  out_q;
  logic       out_valid_q;

  assign load   = q_status_i.valid && (!out_valid_q || !out_stall_i);
  assign at_end = ({1'b0, sub_q} == head_i.num - 3'd1);
  assign pop_o  = load && at_end;

  // one result of the head bundle, picked by the sub-index
  always_comb begin
    res.kind         = head_i.kind;
    res.payload_byte = head_i.bytes[sub_q];
    res.byte_index   = head_i.base_index + 10'(sub_q);
    res.source_id    = head_i.source_id;
    res.dest_id      = head_i.dest_id;
    res.length_byte  = head_i.length_byte;
    res.command_byte = head_i.command_byte;
    res.chunk_flags  = head_i.chunk_flags;
    res.final_flag   = head_i.final_flag;
    res.byte_total   = head_i.byte_total;
    res.last         = at_end;
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sub_q       <= 2'd0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      sub_q       <= at_end ? 2'd0 : sub_q + 2'd1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
